@@ rtl/bsmf_pkg.sv @@
package bsmf_pkg;

    localparam int WORD_W  = 16;
    localparam int LEN_W   = 6;
    localparam int CARRY_W = WORD_W + 1;
    localparam int ACC_W   = 2 * WORD_W + 1;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);

    typedef struct packed {
        logic [WORD_W-1:0] a_word;
        logic [WORD_W-1:0] b_word;
    } bsmf_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] product_word;
        logic              last_word;
    } bsmf_out_t;

endpackage

@@ rtl/bsmf_mac.sv @@
module bsmf_mac
    import bsmf_pkg::*;
(
    input  logic [WORD_W-1:0]  p_word,
    input  logic [WORD_W-1:0]  a_word,
    input  logic [WORD_W-1:0]  b_word,
    input  logic [CARRY_W-1:0] carry_in,
    output logic [ACC_W-1:0]   sum
);

    logic [2*WORD_W-1:0] prod;

    assign prod = a_word * b_word;
    assign sum  = ACC_W'(p_word) + ACC_W'(prod) + ACC_W'(carry_in);

endmodule

@@ rtl/bignum_signed_multiply_full.sv @@
// sequence: L requests load the operands (one per cycle), then a magnitude pass,
// then the multiply-accumulate runs through the single 16x16 mac unit, then each
// product word (2L words) is read from the store and loaded into the output register
// a new multiply is accepted only after the last product word has been loaded out
// reset: control state cleared, length 8, operand and product stores undefined
module bignum_signed_multiply_full
    import bsmf_pkg::*;
#(
    parameter int MAX_WORDS = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  bsmf_in_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output bsmf_out_t        m_data
);

    localparam int IDX_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int PIDX_W = $clog2(2 * MAX_WORDS);
    localparam int CNT_W  = $clog2(MAX_WORDS + 1);
    localparam int OCNT_W = $clog2(2 * MAX_WORDS + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_MAG,
        S_MAC,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    state_t state_reg;

    logic [LEN_W-1:0]     len_reg;
    logic [CNT_W-1:0]     load_cnt_reg;
    logic [MAX_WORDS-1:0] za_reg;
    logic [MAX_WORDS-1:0] zb_reg;
    logic                 run_za_reg;
    logic                 run_zb_reg;
    logic                 sign_a_reg;
    logic                 sign_b_reg;

    logic [CNT_W-1:0]     mag_cnt_reg;
    logic                 mv_reg;
    logic [IDX_W-1:0]     midx_reg;

    logic [IDX_W-1:0]     row_reg;
    logic [CNT_W-1:0]     col_reg;
    logic                 pv_reg;
    logic                 pfirst_reg;
    logic                 plast_reg;
    logic                 pzero_reg;
    logic [PIDX_W-1:0]    pidx_reg;
    logic [CARRY_W-1:0]   carry_reg;
    logic                 cw_reg;
    logic [PIDX_W-1:0]    cw_idx_reg;

    logic [OCNT_W-1:0]    ocnt_reg;
    logic                 nc_reg;
    logic                 m_valid_reg;
    bsmf_out_t            m_data_reg;

    logic [WORD_W-1:0] a_mem [MAX_WORDS];
    logic [WORD_W-1:0] b_mem [MAX_WORDS];
    logic [WORD_W-1:0] p_mem [2*MAX_WORDS];
    logic [WORD_W-1:0] a_rd_reg;
    logic [WORD_W-1:0] b_rd_reg;
    logic [WORD_W-1:0] p_rd_reg;

    logic [LEN_W-1:0]  len_clip;
    logic [CNT_W-1:0]  n_eff;
    logic              s_accept;
    logic              load_last;
    logic              za_cur;
    logic              zb_cur;
    logic              row_last;
    logic              issue;
    logic [PIDX_W-1:0] issue_idx;
    logic [OCNT_W-1:0] olast_idx;

    logic              a_we;
    logic [IDX_W-1:0]  a_waddr;
    logic [WORD_W-1:0] a_wdata;
    logic              b_we;
    logic [IDX_W-1:0]  b_waddr;
    logic [WORD_W-1:0] b_wdata;
    logic [IDX_W-1:0]  a_raddr;
    logic [IDX_W-1:0]  b_raddr;
    logic              p_we;
    logic [PIDX_W-1:0] p_waddr;
    logic [WORD_W-1:0] p_wdata;
    logic [PIDX_W-1:0] p_raddr;

    logic [WORD_W-1:0] mag_a;
    logic [WORD_W-1:0] mag_b;
    logic [WORD_W-1:0] p_in;
    logic [CARRY_W-1:0] carry_in;
    logic [ACC_W-1:0]  mac_sum;
    logic [WORD_W-1:0] out_word;

    always_comb begin
        if (len_reg == '0) begin
            len_clip = LEN_W'(1);
        end else if (len_reg > LEN_W'(MAX_WORDS)) begin
            len_clip = LEN_W'(MAX_WORDS);
        end else begin
            len_clip = len_reg;
        end
    end

    assign n_eff     = CNT_W'(len_clip);
    assign s_ready   = (state_reg == S_LOAD);
    assign s_accept  = s_valid && s_ready;
    assign load_last = (load_cnt_reg == n_eff - CNT_W'(1));
    assign za_cur    = (load_cnt_reg == '0) ? 1'b1 : run_za_reg;
    assign zb_cur    = (load_cnt_reg == '0) ? 1'b1 : run_zb_reg;
    assign row_last  = (CNT_W'(row_reg) == n_eff - CNT_W'(1));
    assign issue     = (state_reg == S_MAC) && (col_reg != n_eff);
    assign issue_idx = PIDX_W'(row_reg) + PIDX_W'(col_reg);
    assign olast_idx = OCNT_W'({n_eff, 1'b0}) - OCNT_W'(1);

    // magnitude: invert and add one where all lower words are zero
    assign mag_a = sign_a_reg ? (~a_rd_reg + WORD_W'(za_reg[midx_reg])) : a_rd_reg;
    assign mag_b = sign_b_reg ? (~b_rd_reg + WORD_W'(zb_reg[midx_reg])) : b_rd_reg;

    assign a_we    = mv_reg || s_accept;
    assign a_waddr = mv_reg ? midx_reg : load_cnt_reg[IDX_W-1:0];
    assign a_wdata = mv_reg ? mag_a : s_data.a_word;
    assign b_we    = mv_reg || s_accept;
    assign b_waddr = mv_reg ? midx_reg : load_cnt_reg[IDX_W-1:0];
    assign b_wdata = mv_reg ? mag_b : s_data.b_word;
    assign a_raddr = (state_reg == S_MAC) ? row_reg : mag_cnt_reg[IDX_W-1:0];
    assign b_raddr = (state_reg == S_MAC) ? col_reg[IDX_W-1:0] : mag_cnt_reg[IDX_W-1:0];

    // first row starts from an all-zero product
    assign p_in     = pzero_reg ? '0 : p_rd_reg;
    assign carry_in = pfirst_reg ? '0 : carry_reg;

    bsmf_mac u_mac (
        .p_word   (p_in),
        .a_word   (a_rd_reg),
        .b_word   (b_rd_reg),
        .carry_in (carry_in),
        .sum      (mac_sum)
    );

    assign p_we    = pv_reg || cw_reg;
    assign p_waddr = pv_reg ? pidx_reg : cw_idx_reg;
    assign p_wdata = pv_reg ? mac_sum[WORD_W-1:0] : carry_reg[WORD_W-1:0];
    assign p_raddr = (state_reg == S_MAC) ? issue_idx : ocnt_reg[PIDX_W-1:0];

    // product negation rippled while streaming out
    assign out_word = (sign_a_reg ^ sign_b_reg) ? (~p_rd_reg + WORD_W'(nc_reg)) : p_rd_reg;

    always_ff @(posedge aclk) begin
        if (a_we) begin
            a_mem[a_waddr] <= a_wdata;
        end
        if (b_we) begin
            b_mem[b_waddr] <= b_wdata;
        end
        a_rd_reg <= a_mem[a_raddr];
        b_rd_reg <= b_mem[b_raddr];
    end

    always_ff @(posedge aclk) begin
        if (p_we) begin
            p_mem[p_waddr] <= p_wdata;
        end
        p_rd_reg <= p_mem[p_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            len_reg      <= LEN_RESET;
            load_cnt_reg <= '0;
            mv_reg       <= 1'b0;
            pv_reg       <= 1'b0;
            cw_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            mv_reg <= 1'b0;
            pv_reg <= 1'b0;
            cw_reg <= pv_reg && plast_reg;
            if (pv_reg) begin
                carry_reg <= mac_sum[ACC_W-1:WORD_W];
                if (plast_reg) begin
                    cw_idx_reg <= pidx_reg + PIDX_W'(1);
                end
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_LOAD: begin
                    if (s_accept) begin
                        za_reg[load_cnt_reg[IDX_W-1:0]] <= za_cur;
                        zb_reg[load_cnt_reg[IDX_W-1:0]] <= zb_cur;
                        run_za_reg <= za_cur && (s_data.a_word == '0);
                        run_zb_reg <= zb_cur && (s_data.b_word == '0);
                        if (load_last) begin
                            sign_a_reg   <= s_data.a_word[WORD_W-1];
                            sign_b_reg   <= s_data.b_word[WORD_W-1];
                            load_cnt_reg <= '0;
                            mag_cnt_reg  <= '0;
                            state_reg    <= S_MAG;
                        end else begin
                            load_cnt_reg <= load_cnt_reg + CNT_W'(1);
                        end
                    end
                end
                S_MAG: begin
                    if (mag_cnt_reg != n_eff) begin
                        mv_reg      <= 1'b1;
                        midx_reg    <= mag_cnt_reg[IDX_W-1:0];
                        mag_cnt_reg <= mag_cnt_reg + CNT_W'(1);
                    end else begin
                        row_reg   <= '0;
                        col_reg   <= '0;
                        state_reg <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (issue) begin
                        pv_reg     <= 1'b1;
                        pidx_reg   <= issue_idx;
                        pfirst_reg <= (col_reg == '0);
                        plast_reg  <= (col_reg == n_eff - CNT_W'(1));
                        pzero_reg  <= (row_reg == '0);
                        col_reg    <= col_reg + CNT_W'(1);
                    end else if (row_last) begin
                        ocnt_reg  <= '0;
                        nc_reg    <= 1'b1;
                        state_reg <= S_EMIT_RD;
                    end else begin
                        row_reg <= row_reg + IDX_W'(1);
                        col_reg <= '0;
                    end
                end
                S_EMIT_RD: begin
                    state_reg <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg             <= 1'b1;
                        m_data_reg.product_word <= out_word;
                        m_data_reg.last_word    <= (ocnt_reg == olast_idx);
                        nc_reg                  <= nc_reg && (p_rd_reg == '0);
                        ocnt_reg                <= ocnt_reg + OCNT_W'(1);
                        if (ocnt_reg == olast_idx) begin
                            state_reg <= S_LOAD;
                        end else begin
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase

            // new length abandons a partly loaded run
            if (cfg_we) begin
                len_reg      <= cfg_wdata;
                load_cnt_reg <= '0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
